FILE: src/sscd_pkg.sv
// ----------------------------------------------------------------------------
// sscd_pkg
// shared types, constants and helpers of the stereo soft clip / dc blocker
// ----------------------------------------------------------------------------
package sscd_pkg;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} out_t;

	// arithmetic steps of one channel, in issue order
	typedef enum logic [2:0] {
		ST_GAIN  = 3'd0,
		ST_RECIP = 3'd1,
		ST_SQ    = 3'd2,
		ST_CUBE  = 3'd3,
		ST_DIV3  = 3'd4,
		ST_SCALE = 3'd5,
		ST_DC    = 3'd6
	} step_t;

	localparam int N_STEPS  = 7;
	localparam int N_CHAN   = 2;
	localparam int LAST_CNT = N_STEPS * N_CHAN;
	localparam int CNT_W    = $clog2(LAST_CNT + 1);

	// shared multiplier
	localparam int MUL_W  = 27;
	localparam int PROD_W = 2 * MUL_W;

	typedef struct packed {
		logic  vld;
		step_t step;
		logic  ch;
	} tag_t;

	typedef struct packed {
		logic  in_ready;
		logic  load_out;
		tag_t  issue;
	} ctrl_t;

	localparam logic [14:0] GAIN_BYPASS = 15'd32767;
	localparam logic [14:0] GAIN_RESET  = 15'd32767;
	localparam int          KNEE_THR    = 18000;
	localparam int          KNEE_RANGE  = 14768;
	localparam int          DC_COEF     = 32669;
	localparam int          Q_SH        = 15;

	// over*32768/14768 == (over<<11)/923, done as a reciprocal multiply
	localparam int RECIP_PRE = 11;
	localparam int RECIP_M   = 37226153;
	localparam int RECIP_SH  = 35;
	// divide by three for values below 2^16
	localparam int DIV3_M    = 87382;
	localparam int DIV3_SH   = 18;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		if (v > 32'sd32767) begin
			return 16'sh7fff;
		end else if (v < -32'sd32768) begin
			return 16'sh8000;
		end else begin
			return $signed(v[15:0]);
		end
	endfunction

endpackage

FILE: src/stereo_soft_clip_dc_blocker_top.sv
// ----------------------------------------------------------------------------
// stereo_soft_clip_dc_blocker_top
// master gain, cubic soft knee and dc blocker for stereo q15 frames
// ----------------------------------------------------------------------------
// A frame is taken when the block is idle and its result is loaded into the
// output register once all of its products have been absorbed; the next frame
// can be taken only after that, so the block does not take a new frame before
// it is through with the last one. The fourteen multiplications per frame (seven
// per channel, left and right interleaved) all pass through one shared
// 27x27 registered multiplier. A waiting output word blocks the next frame:
// the finished frame is held back until the output register is free, and no
// new frame is accepted before then.
// master_gain may be written at any time the block is idle and applies from
// the next frame on; the dc blocker history of both channels clears on reset.
// ----------------------------------------------------------------------------
module stereo_soft_clip_dc_blocker_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [14:0]    cfg_wr_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  sscd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sscd_pkg::out_t out_data
);

	localparam int MW = sscd_pkg::MUL_W;
	localparam int PW = sscd_pkg::PROD_W;
	localparam int NC = sscd_pkg::N_CHAN;

	sscd_pkg::ctrl_t ctrl;
	sscd_pkg::tag_t  ptag;
	logic signed [PW-1:0] prod;
	logic signed [MW-1:0] op_a;
	logic signed [MW-1:0] op_b;

	logic [14:0] gain_q;
	logic        out_valid_q;
	sscd_pkg::out_t out_q;
	logic        slot_free;
	logic        in_acc;

	// per-channel working registers
	logic signed [15:0] smp_q   [NC];
	logic signed [15:0] v_q     [NC];
	logic               neg_q   [NC];
	logic               knee_q  [NC];
	logic [14:0]        over_q  [NC];
	logic [16:0]        r_q     [NC];
	logic [16:0]        r2_q    [NC];
	logic [16:0]        u_q     [NC];
	logic [14:0]        sh_q    [NC];
	logic signed [15:0] clip_q  [NC];
	logic signed [15:0] px_q    [NC];
	logic signed [31:0] py_q    [NC];

	// absorb-side values
	logic               ach;
	logic signed [15:0] g_v;
	logic signed [16:0] g_vx;
	logic signed [16:0] g_ov;
	logic               g_knee;
	logic               g_neg;
	logic [16:0]        d_diff;
	logic [13:0]        d_q3;
	logic [14:0]        d_sh;
	logic [13:0]        s_kn;
	logic signed [16:0] s_kv;
	logic signed [15:0] s_clip;
	logic signed [31:0] dc_y;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = ctrl.in_ready;
	assign in_acc    = in_valid && ctrl.in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	sscd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.slot_free (slot_free),
		.ctrl      (ctrl)
	);

	sscd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_a    (op_a),
		.op_b    (op_b),
		.tag_in  (ctrl.issue),
		.prod    (prod),
		.tag_out (ptag)
	);

	// operand select for the step being issued
	always_comb begin
		logic c;
		c    = ctrl.issue.ch;
		op_a = '0;
		op_b = '0;
		case (ctrl.issue.step)
			sscd_pkg::ST_GAIN: begin
				op_a = MW'(smp_q[c]);
				op_b = MW'({1'b0, gain_q});
			end
			sscd_pkg::ST_RECIP: begin
				op_a = MW'({over_q[c], {sscd_pkg::RECIP_PRE{1'b0}}});
				op_b = MW'(sscd_pkg::RECIP_M);
			end
			sscd_pkg::ST_SQ: begin
				op_a = MW'(r_q[c]);
				op_b = MW'(r_q[c]);
			end
			sscd_pkg::ST_CUBE: begin
				op_a = MW'(r2_q[c]);
				op_b = MW'(r_q[c]);
			end
			sscd_pkg::ST_DIV3: begin
				op_a = MW'(u_q[c]);
				op_b = MW'(sscd_pkg::DIV3_M);
			end
			sscd_pkg::ST_SCALE: begin
				op_a = MW'(sh_q[c]);
				op_b = MW'(sscd_pkg::KNEE_RANGE);
			end
			sscd_pkg::ST_DC: begin
				op_a = $signed(py_q[c][MW-1:0]);
				op_b = MW'(sscd_pkg::DC_COEF);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// results of the product now in the multiplier register
	always_comb begin
		ach = ptag.ch;

		// gain and knee detection
		g_v    = (gain_q == sscd_pkg::GAIN_BYPASS) ? smp_q[ach]
			: $signed(prod[30:15]);
		g_vx   = 17'(g_v);
		g_knee = 1'b0;
		g_neg  = 1'b0;
		g_ov   = '0;
		if (g_vx > 17'(sscd_pkg::KNEE_THR)) begin
			g_knee = 1'b1;
			g_ov   = g_vx - 17'(sscd_pkg::KNEE_THR);
		end else if (g_vx < -17'(sscd_pkg::KNEE_THR)) begin
			g_knee = 1'b1;
			g_neg  = 1'b1;
			g_ov   = -17'(sscd_pkg::KNEE_THR) - g_vx;
		end

		// shaped = r - u/3, capped
		d_q3   = prod[sscd_pkg::DIV3_SH+13:sscd_pkg::DIV3_SH];
		d_diff = r_q[ach] - {3'b000, d_q3};
		d_sh   = (d_diff > 17'd32767) ? 15'd32767 : d_diff[14:0];

		// back to the knee range and rebuild the sample
		s_kn   = prod[sscd_pkg::Q_SH+13:sscd_pkg::Q_SH];
		s_kv   = neg_q[ach] ? (-17'(sscd_pkg::KNEE_THR) - 17'(s_kn))
			: (17'(sscd_pkg::KNEE_THR) + 17'(s_kn));
		s_clip = knee_q[ach] ? s_kv[15:0] : v_q[ach];

		// one-pole blocker, floor shift of the feedback product
		dc_y = 32'(clip_q[ach]) - 32'(px_q[ach]) + $signed(prod[46:15]);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q[0] <= in_data.left_in;
			smp_q[1] <= in_data.right_in;
		end
		if (ptag.vld) begin
			case (ptag.step)
				sscd_pkg::ST_GAIN: begin
					v_q[ach]    <= g_v;
					knee_q[ach] <= g_knee;
					neg_q[ach]  <= g_neg;
					over_q[ach] <= g_ov[14:0];
				end
				sscd_pkg::ST_RECIP: begin
					r_q[ach] <= prod[sscd_pkg::RECIP_SH+16:sscd_pkg::RECIP_SH];
				end
				sscd_pkg::ST_SQ: begin
					r2_q[ach] <= prod[sscd_pkg::Q_SH+16:sscd_pkg::Q_SH];
				end
				sscd_pkg::ST_CUBE: begin
					u_q[ach] <= prod[sscd_pkg::Q_SH+16:sscd_pkg::Q_SH];
				end
				sscd_pkg::ST_DIV3: begin
					sh_q[ach] <= d_sh;
				end
				sscd_pkg::ST_SCALE: begin
					clip_q[ach] <= s_clip;
				end
				default: begin
				end
			endcase
		end
		if (ctrl.load_out) begin
			out_q.left_out  <= sscd_pkg::sat16(py_q[0]);
			out_q.right_out <= sscd_pkg::sat16(py_q[1]);
		end
	end

	// blocker history, gain register and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= sscd_pkg::GAIN_RESET;
			out_valid_q <= 1'b0;
			px_q[0]     <= '0;
			px_q[1]     <= '0;
			py_q[0]     <= '0;
			py_q[1]     <= '0;
		end else begin
			if (cfg_wr_en) begin
				gain_q <= cfg_wr_data;
			end
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ptag.vld && (ptag.step == sscd_pkg::ST_DC)) begin
				px_q[ach] <= clip_q[ach];
				py_q[ach] <= dc_y;
			end
		end
	end

endmodule

FILE: src/sscd_mul.sv
// ----------------------------------------------------------------------------
// sscd_mul
// shared signed multiplier with registered product and operation tag
// ----------------------------------------------------------------------------
module sscd_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [sscd_pkg::MUL_W-1:0]   op_a,
	input  logic signed [sscd_pkg::MUL_W-1:0]   op_b,
	input  sscd_pkg::tag_t                      tag_in,
	output logic signed [sscd_pkg::PROD_W-1:0]  prod,
	output sscd_pkg::tag_t                      tag_out
);

	logic signed [sscd_pkg::PROD_W-1:0] prod_s1;
	sscd_pkg::tag_t                     tag_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= sscd_pkg::PROD_W'(op_a) * sscd_pkg::PROD_W'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	assign prod    = prod_s1;
	assign tag_out = tag_s1;

endmodule

FILE: src/sscd_ctrl.sv
// ----------------------------------------------------------------------------
// sscd_ctrl
// sequencer: steps both channels alternately through the shared multiplier
// ----------------------------------------------------------------------------
module sscd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            slot_free,
	output sscd_pkg::ctrl_t ctrl
);

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_RUN  = 3'b010,
		FSM_DONE = 3'b100
	} fsm_t;

	fsm_t                       state_q;
	logic [sscd_pkg::CNT_W-1:0] cnt_q;
	logic                       last;

	assign last = (cnt_q == sscd_pkg::CNT_W'(sscd_pkg::LAST_CNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= FSM_RUN;
					end
				end
				FSM_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					// last count only drains the multiplier
					if (last) begin
						state_q <= FSM_DONE;
					end
				end
				FSM_DONE: begin
					if (slot_free) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctrl.in_ready   = (state_q == FSM_IDLE);
		ctrl.load_out   = (state_q == FSM_DONE) && slot_free;
		ctrl.issue.vld  = (state_q == FSM_RUN) && !last;
		ctrl.issue.step = sscd_pkg::step_t'(cnt_q[3:1]);
		ctrl.issue.ch   = cnt_q[0];
	end

endmodule

FILE: bench/sscd_checker.sv
// ----------------------------------------------------------------------------
// sscd_checker
// watches both word channels, predicts every output frame and compares it
// ----------------------------------------------------------------------------
// Keeps its own copy of the master gain and of the dc blocker history of each
// channel. Every accepted input word queues one predicted output frame, and
// every accepted output word is checked against the oldest of them.
// ----------------------------------------------------------------------------
module sscd_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [14:0]    cfg_wr_data,
	input  logic           in_valid,
	input  logic           in_ready,
	input  sscd_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  sscd_pkg::out_t out_data,
	output int             n_fail,
	output int             n_wait
);

	logic [14:0]        gain_q;
	logic signed [15:0] blk_x_prev [sscd_pkg::N_CHAN];
	int                 blk_y_prev [sscd_pkg::N_CHAN];
	sscd_pkg::out_t     frame_q [$];
	int                 fails = 0;
	int                 waiting = 0;

	assign n_fail = fails;
	assign n_wait = waiting;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fails++;
	endtask

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// amount by which the knee lets a sample rise above the threshold
	function automatic longint knee_lift(input longint over);
		longint r, r2, shaped;
		r = (over * 32768) / sscd_pkg::KNEE_RANGE;
		if (r > 32768) begin
			r = 32768;
		end
		r2 = (r * r) / 32768;
		shaped = r - ((r2 * r) / 3) / 32768;
		if (shaped > 32767) begin
			shaped = 32767;
		end
		return (shaped * sscd_pkg::KNEE_RANGE) / 32768;
	endfunction

	// gain and soft knee, ahead of the blocker
	function automatic logic signed [15:0] shape_sample(input logic signed [15:0] s,
			input logic [14:0] g);
		longint v;
		if (g != sscd_pkg::GAIN_BYPASS) begin
			v = (longint'(s) * longint'(g)) >>> sscd_pkg::Q_SH;
		end else begin
			v = s;
		end
		if (v > sscd_pkg::KNEE_THR) begin
			v = sscd_pkg::KNEE_THR + knee_lift(v - sscd_pkg::KNEE_THR);
		end else if (v < -sscd_pkg::KNEE_THR) begin
			v = -sscd_pkg::KNEE_THR - knee_lift(-sscd_pkg::KNEE_THR - v);
		end
		return clamp16(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sscd_pkg::out_t     want;
		logic signed [15:0] smp [sscd_pkg::N_CHAN];
		logic signed [15:0] res [sscd_pkg::N_CHAN];
		logic signed [15:0] x;
		longint             y;
		if (!arst_n) begin
			gain_q = sscd_pkg::GAIN_RESET;
			for (int c = 0; c < sscd_pkg::N_CHAN; c++) begin
				blk_x_prev[c] = '0;
				blk_y_prev[c] = 0;
			end
			frame_q.delete();
		end else begin
			// output side first: a word leaving now never belongs to one arriving now
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					report_mismatch($sformatf("output word %h with no frame outstanding",
						out_data));
				end else begin
					want = frame_q.pop_front();
					if (out_data.left_out !== want.left_out) begin
						report_mismatch($sformatf("left_out got %0d want %0d",
							out_data.left_out, want.left_out));
					end
					if (out_data.right_out !== want.right_out) begin
						report_mismatch($sformatf("right_out got %0d want %0d",
							out_data.right_out, want.right_out));
					end
				end
			end
			if (in_valid && in_ready) begin
				smp[0] = in_data.left_in;
				smp[1] = in_data.right_in;
				for (int c = 0; c < sscd_pkg::N_CHAN; c++) begin
					x = shape_sample(smp[c], gain_q);
					y = longint'(x) - longint'(blk_x_prev[c])
						+ ((longint'(blk_y_prev[c]) * sscd_pkg::DC_COEF) >>> sscd_pkg::Q_SH);
					blk_x_prev[c] = x;
					// history keeps the unclamped value
					blk_y_prev[c] = int'(y);
					res[c] = clamp16(y);
				end
				want.left_out  = res[0];
				want.right_out = res[1];
				frame_q.push_back(want);
			end
			if (cfg_wr_en) begin
				gain_q = cfg_wr_data;
			end
			waiting = frame_q.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the stereo soft clip / dc blocker
// ----------------------------------------------------------------------------
// Drives directed frames at the sample extremes, the knee threshold and
// several gain settings, then random frames in phases with a new gain each
// and different amounts of sender idling and receiver stalling. Prediction
// and comparison sit in sscd_checker.
// ----------------------------------------------------------------------------
module tb_top;

	logic           clk;
	logic           arst_n;
	logic           cfg_wr_en;
	logic [14:0]    cfg_wr_data;
	logic           in_valid;
	logic           in_ready;
	sscd_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	sscd_pkg::out_t out_data;
	int             n_fail;
	int             n_wait;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_go = 1'b0;

	stereo_soft_clip_dc_blocker_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	sscd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.n_fail      (n_fail),
		.n_wait      (n_wait)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked for
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {l, r};
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (n_wait != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic set_gain(input logic [14:0] g);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= g;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample();
		int v;
		case ($urandom_range(9))
			4, 5: begin
				v = sscd_pkg::KNEE_THR + $urandom_range(sscd_pkg::KNEE_RANGE);
				v = $urandom_range(1) ? v : -v;
			end
			6: v = $urandom_range(1) ? 32767 : -32768;
			7: v = int'($urandom_range(200)) - 100;
			8: begin
				v = sscd_pkg::KNEE_THR - 10 + $urandom_range(20);
				v = $urandom_range(1) ? v : -v;
			end
			default: v = $urandom;
		endcase
		return v[15:0];
	endfunction

	initial begin
		logic [14:0] g;
		int          n_items;
		arst_n      = 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset gain bypasses the multiply; knee edges and blocker overshoot
		send_frame(16'sd0, 16'sd0);
		send_frame(16'sd32767, -16'sd32768);
		send_frame(-16'sd32768, 16'sd32767);
		send_frame(16'sd32767, -16'sd32768);
		send_frame(16'sd18000, -16'sd18000);
		send_frame(16'sd18001, -16'sd18001);
		send_frame(16'sd25000, -16'sd25000);
		send_frame(-16'sd1, 16'sd1);
		// zero gain silences both channels ahead of the blocker
		set_gain(15'd0);
		send_frame(16'sd12345, -16'sd32768);
		send_frame(16'sd32767, -16'sd1);
		// half gain, negative products round towards minus infinity
		set_gain(15'd16384);
		send_frame(-16'sd1, -16'sd3);
		send_frame(-16'sd32768, 16'sd32767);
		send_frame(16'sd30001, -16'sd30001);
		set_gain(15'd1);
		send_frame(-16'sd32768, 16'sd32767);
		send_frame(-16'sd1, 16'sd1);
		// one below bypass still goes through the multiply
		set_gain(15'd32766);
		send_frame(16'sd32767, -16'sd32768);
		send_frame(-16'sd32768, 16'sd32767);
		send_frame(-16'sd20000, 16'sd20000);
		set_gain(15'd32767);
		send_frame(16'sd0, 16'sd0);
		send_frame(-16'sd32768, -16'sd32768);
		send_frame(16'sd32767, 16'sd32767);

		for (int p = 0; p < 9; p++) begin
			case (p)
				0:       g = 15'd32767;
				1:       g = 15'd0;
				2:       g = 15'd1;
				3:       g = 15'd16384;
				4:       g = 15'd32766;
				8:       g = 15'd32767;
				default: g = 15'($urandom_range(32767));
			endcase
			set_gain(g);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
			endcase
			n_items = 140;
			if (p == 0) begin
				// long receiver hold-off while frames keep coming, so the input stalls
				@(posedge clk);
				hold_go = 1'b1;
				@(negedge clk);
				n_items = 200;
			end
			for (int k = 0; k < n_items; k++) begin
				send_frame(pick_sample(), pick_sample());
			end
		end

		drain();
		repeat (40) @(negedge clk);
		if (n_fail == 0 && n_wait == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
